FILE: hw/rtl/bsfr_pkg.sv
// Shared constants, codes and control structs for the byte-stuffed frame receiver.
package bsfr_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int MIN_W  = 5;
    localparam int RAW_W  = 13;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    localparam logic [RAW_W-1:0] MIN_RESET = 13'd4;
    localparam logic [RAW_W-1:0] MAX_RESET = 13'd500;

    localparam logic [HOLD_CW-1:0] HOLD_DEPTH_C   = HOLD_CW'(HOLD_DEPTH);
    localparam logic [RAW_W-1:0]   HOLD_DEPTH_RAW = RAW_W'(HOLD_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 2'd0,
        KIND_END      = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    localparam logic CFG_MIN_RAW_LEN = 1'b0;
    localparam logic CFG_MAX_RAW_LEN = 1'b1;

    typedef struct packed {
        logic take;
        logic flush_emit;
        logic end_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic go_end;
        logic go_flush;
        logic flush_last;
    } t_dp_stat;

endpackage

FILE: hw/rtl/byte_stuffed_frame_receiver_core.sv
// Top level of the byte-stuffed frame receiver: controller plus datapath.
//
// channel | dir | handshake               | payload
// s       | in  | i_s_tvalid/o_s_tready   | tdata[7:0] rx_byte
// m       | out | o_m_tvalid/i_m_tready   | tdata[7:0] data_byte, tuser[1:0] kind, tlast
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data[12:0]
//
// One raw byte per cycle while the output register drains and no release or end
// marker is pending; a byte that yields a result loads the output register in the
// cycle it is accepted. A release of held bytes (up to 15) emits them one by one
// before the next request; an escaped closing flag is followed by an end marker.
// Reset is synchronous, active low; the hold store needs no clearing.
// A stalled output blocks input acceptance until the output register frees.
module byte_stuffed_frame_receiver_core
    import bsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] rx_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,   // [7:0] data_byte
    output logic [KIND_W-1:0] o_m_tuser,   // [1:0] kind
    output logic              o_m_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [RAW_W-1:0]  i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bsfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    bsfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_rx_byte   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: hw/rtl/bsfr_ctrl.sv
// Controller state machine: input acceptance and sequencing of multi-result requests.
module bsfr_ctrl
    import bsfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_FLUSH = 3'b010,
        S_END   = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.take       = 1'b0;
        o_cmd.flush_emit = 1'b0;
        o_cmd.end_emit   = 1'b0;
        case (r_state)
            S_RUN: begin
                o_in_ready = i_stat.slot_free;
                o_cmd.take = i_in_valid && i_stat.slot_free;
                if (o_cmd.take) begin
                    if (i_stat.go_end) begin
                        n_state = S_END;
                    end else if (i_stat.go_flush) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.slot_free) begin
                    o_cmd.flush_emit = 1'b1;
                    if (i_stat.flush_last) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_END: begin
                if (i_stat.slot_free) begin
                    o_cmd.end_emit = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/bsfr_datapath.sv
// Datapath: frame state, unstuffing, hold store, config registers and output register.
module bsfr_datapath
    import bsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [RAW_W-1:0]  i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [BYTE_W-1:0] o_m_tdata,
    output logic [KIND_W-1:0] o_m_tuser,
    output logic              o_m_tlast
);

    logic [MIN_W-1:0]   r_min;
    logic [RAW_W-1:0]   r_max;
    logic               r_in_frame, n_in_frame;
    logic               r_esc, n_esc;
    logic [RAW_W-1:0]   r_raw, n_raw;
    logic               r_rel, n_rel;
    logic [HOLD_CW-1:0] r_hcnt, n_hcnt;
    logic [HOLD_AW-1:0] r_fl_idx, n_fl_idx;
    logic [HOLD_CW-1:0] r_fl_cnt, n_fl_cnt;
    logic [BYTE_W-1:0]  r_hold [HOLD_DEPTH];

    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_data, n_out_data;
    t_kind              r_out_kind, n_out_kind;
    logic               r_out_last, n_out_last;

    logic [RAW_W-1:0]   w_min_ext;
    logic [RAW_W-1:0]   w_eff_min;
    logic [RAW_W-1:0]   w_raw_inc;
    logic               w_ovf;
    logic               w_is_flag;
    logic               w_is_esc;
    logic               w_close_ok;
    logic               w_have;
    logic [BYTE_W-1:0]  w_d;
    logic               w_store;
    logic [HOLD_CW-1:0] w_fl_cnt;
    logic               w_flush_last;
    logic               w_slot_free;
    logic               w_go_end;
    logic               w_go_flush;
    logic               w_load;
    logic [BYTE_W-1:0]  w_ld_data;
    t_kind              w_ld_kind;
    logic               w_ld_last;

    assign o_cfg_ready  = 1'b1;
    assign w_slot_free  = !r_out_valid || i_m_tready;
    assign w_min_ext    = RAW_W'(r_min);
    assign w_eff_min    = (w_min_ext > HOLD_DEPTH_RAW) ? HOLD_DEPTH_RAW : w_min_ext;
    assign w_raw_inc    = r_raw + 1'b1;
    assign w_ovf        = ({1'b0, r_raw} + 1'b1) >= {1'b0, r_max};
    assign w_is_flag    = (i_rx_byte == FLAG_BYTE);
    assign w_is_esc     = (i_rx_byte == ESC_BYTE);
    assign w_close_ok   = r_rel && (r_raw >= w_eff_min);
    assign w_have       = r_esc || !w_is_esc;
    assign w_d          = r_esc ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;
    assign w_flush_last = ((HOLD_CW'(r_fl_idx) + 1'b1) == r_fl_cnt);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_esc       = r_esc;
        n_raw       = r_raw;
        n_rel       = r_rel;
        n_hcnt      = r_hcnt;
        n_fl_idx    = r_fl_idx;
        n_fl_cnt    = r_fl_cnt;
        w_load      = 1'b0;
        w_ld_data   = '0;
        w_ld_kind   = KIND_DATA;
        w_ld_last   = 1'b1;
        w_store     = 1'b0;
        w_fl_cnt    = '0;
        w_go_end    = 1'b0;
        w_go_flush  = 1'b0;

        if (i_cmd.take) begin
            if (!r_in_frame || w_is_flag) begin
                if (r_in_frame && w_close_ok) begin
                    w_load = 1'b1;
                    if (r_esc) begin
                        w_ld_data = FLAG_BYTE ^ ESC_XOR;
                        w_ld_last = 1'b0;
                        w_go_end  = 1'b1;
                    end else begin
                        w_ld_kind = KIND_END;
                    end
                end
                if (w_is_flag) begin
                    n_in_frame = 1'b1;
                    n_esc      = 1'b0;
                    n_raw      = RAW_W'(1);
                    n_hcnt     = '0;
                    n_rel      = (w_eff_min <= RAW_W'(1));
                end
            end else if (w_ovf) begin
                w_load     = 1'b1;
                w_ld_kind  = KIND_OVERFLOW;
                n_in_frame = 1'b0;
                n_esc      = 1'b0;
                n_raw      = '0;
                n_rel      = 1'b0;
                n_hcnt     = '0;
            end else begin
                n_raw = w_raw_inc;
                n_esc = !r_esc && w_is_esc;
                if (w_have && r_rel) begin
                    w_load    = 1'b1;
                    w_ld_data = w_d;
                end
                w_store = w_have && !r_rel && (r_hcnt < HOLD_DEPTH_C);
                if (!r_rel && (w_raw_inc >= w_eff_min)) begin
                    w_fl_cnt = r_hcnt + HOLD_CW'(w_store);
                    n_rel    = 1'b1;
                    n_hcnt   = '0;
                    if (w_fl_cnt != '0) begin
                        w_go_flush = 1'b1;
                        n_fl_idx   = '0;
                        n_fl_cnt   = w_fl_cnt;
                    end
                end else if (w_store) begin
                    n_hcnt = r_hcnt + 1'b1;
                end
            end
        end

        if (i_cmd.flush_emit) begin
            w_load    = 1'b1;
            w_ld_data = r_hold[r_fl_idx];
            w_ld_last = w_flush_last;
            n_fl_idx  = r_fl_idx + 1'b1;
        end

        if (i_cmd.end_emit) begin
            w_load    = 1'b1;
            w_ld_kind = KIND_END;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_data  = w_ld_data;
            n_out_kind  = w_ld_kind;
            n_out_last  = w_ld_last;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stat.slot_free  = w_slot_free;
    assign o_stat.go_end     = w_go_end;
    assign o_stat.go_flush   = w_go_flush;
    assign o_stat.flush_last = w_flush_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_W'(MIN_RESET);
            r_max       <= MAX_RESET;
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_raw       <= '0;
            r_rel       <= 1'b0;
            r_hcnt      <= '0;
            r_fl_idx    <= '0;
            r_fl_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_RAW_LEN) begin
                    r_min <= i_cfg_data[MIN_W-1:0];
                end else begin
                    r_max <= i_cfg_data;
                end
            end
            r_in_frame  <= n_in_frame;
            r_esc       <= n_esc;
            r_raw       <= n_raw;
            r_rel       <= n_rel;
            r_hcnt      <= n_hcnt;
            r_fl_idx    <= n_fl_idx;
            r_fl_cnt    <= n_fl_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        if (w_store) begin
            r_hold[r_hcnt[HOLD_AW-1:0]] <= w_d;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
